// File: design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsr assertion failed");

// antecedent implies consequent in the next cycle
`define RSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsr assertion failed");

`endif

// File: design/rsr_pkg.sv
// types and constants for the relative sprite resolver
// no dependencies
package rsr_pkg;

  localparam logic [7:0] REL_MASK    = 8'hC0;
  localparam logic [7:0] REL_CODE    = 8'h40;

  localparam logic [1:0] KIND_ANCHOR    = 2'd0;
  localparam logic [1:0] KIND_COMPOSITE = 2'd1;
  localparam logic [1:0] KIND_UNIFIED   = 2'd2;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] attr0_byte;
    logic [7:0] attr1_byte;
    logic [7:0] attr2_byte;
    logic [7:0] attr3_byte;
    logic [7:0] attr4_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] x_position;
    logic signed [11:0] y_position;
    logic [6:0]         pattern_index;
    logic               four_bit_pattern;
    logic [3:0]         palette_offset;
    logic               rotate_pattern;
    logic               flip_x;
    logic               flip_y;
    logic [1:0]         x_scale_log;
    logic [1:0]         y_scale_log;
    logic [1:0]         relative_kind;
  } out_item_t;

  typedef struct packed {
    logic       visible;
    logic [8:0] x;
    logic [8:0] y;
    logic [6:0] pattern;
    logic       four_bit;
    logic [3:0] palette;
    logic       unified;
    logic       rotate;
    logic       flip_x;
    logic       flip_y;
    logic [1:0] x_scale;
    logic [1:0] y_scale;
  } anchor_t;

  typedef struct packed {
    logic      emit;
    logic      relative;
    out_item_t item;
  } resolve_t;

endpackage

// File: design/rsr_resolve.sv
// decodes one sprite's attributes and resolves it against the anchor
// depends on rsr_pkg
module rsr_resolve (
  input  rsr_pkg::in_item_t item_i,
  input  rsr_pkg::anchor_t  anchor_i,
  output rsr_pkg::resolve_t res_o,
  output rsr_pkg::anchor_t  anchor_nxt
);
  import rsr_pkg::*;

  anchor_t            anc;
  logic [3:0]         pal;
  logic               mx, my, rot, bit0, vis, ext, rel;
  logic [5:0]         hi;
  logic               h, n6, t, y8, po;
  logic [1:0]         xs, ys;
  logic [6:0]         n_raw, n_res;
  logic [7:0]         xd0, yd0, xd1, yd1, xd2, yd2;
  logic signed [11:0] xd12, yd12, xoff, yoff, ax12, ay12;
  logic               four;

  always_comb begin
    // frame start clears the anchor ahead of this sprite
    anc  = item_i.frame_start ? '0 : anchor_i;
    pal  = item_i.attr2_byte[7:4];
    mx   = item_i.attr2_byte[3];
    my   = item_i.attr2_byte[2];
    rot  = item_i.attr2_byte[1];
    bit0 = item_i.attr2_byte[0];
    vis  = item_i.attr3_byte[7];
    ext  = item_i.attr3_byte[6];
    hi   = item_i.attr3_byte[5:0];
    rel  = ext && ((item_i.attr4_byte & REL_MASK) == REL_CODE);
    xs   = ext ? item_i.attr4_byte[4:3] : 2'd0;
    ys   = ext ? item_i.attr4_byte[2:1] : 2'd0;
    h    = ext && !rel && item_i.attr4_byte[7];
    t    = ext && !rel && item_i.attr4_byte[5];
    y8   = ext && !rel && item_i.attr4_byte[0];
    po   = rel && item_i.attr4_byte[0];
    n6   = ext && (rel ? item_i.attr4_byte[5] : item_i.attr4_byte[6]);
    n_raw = {hi, n6};

    // unified offset transform, negation wraps in eight bits
    xd0 = item_i.attr0_byte;
    yd0 = item_i.attr1_byte;
    xd1 = anc.rotate ? 8'(8'd0 - yd0) : xd0;
    yd1 = anc.rotate ? xd0 : yd0;
    xd2 = anc.flip_x ? 8'(8'd0 - xd1) : xd1;
    yd2 = anc.flip_y ? 8'(8'd0 - yd1) : yd1;
    xd12 = signed'({{4{xd2[7]}}, xd2});
    yd12 = signed'({{4{yd2[7]}}, yd2});
    ax12 = signed'({3'b000, anc.x});
    ay12 = signed'({3'b000, anc.y});

    anchor_nxt = anc;
    res_o      = '0;
    res_o.relative = rel;
    xoff       = '0;
    yoff       = '0;

    if (!rel) begin
      anchor_nxt.visible  = vis;
      anchor_nxt.x        = {bit0, item_i.attr0_byte};
      anchor_nxt.y        = {y8, item_i.attr1_byte};
      anchor_nxt.pattern  = n_raw;
      anchor_nxt.four_bit = h;
      anchor_nxt.palette  = pal;
      anchor_nxt.unified  = t;
      anchor_nxt.rotate   = rot;
      anchor_nxt.flip_x   = mx;
      anchor_nxt.flip_y   = my;
      anchor_nxt.x_scale  = xs;
      anchor_nxt.y_scale  = ys;
      four = h;
      n_res = n_raw;
      res_o.emit                = vis;
      res_o.item.x_position     = signed'({3'b000, bit0, item_i.attr0_byte});
      res_o.item.y_position     = signed'({3'b000, y8, item_i.attr1_byte});
      res_o.item.palette_offset = pal;
      res_o.item.rotate_pattern = rot;
      res_o.item.flip_x         = mx;
      res_o.item.flip_y         = my;
      res_o.item.x_scale_log    = xs;
      res_o.item.y_scale_log    = ys;
      res_o.item.relative_kind  = KIND_ANCHOR;
    end else begin
      four  = anc.four_bit;
      n_res = po ? 7'(n_raw + anc.pattern) : n_raw;
      res_o.emit                = anc.visible && vis;
      res_o.item.palette_offset = bit0 ? 4'(anc.palette + pal) : pal;
      if (anc.unified) begin
        xoff = xd12 <<< anc.x_scale;
        yoff = yd12 <<< anc.y_scale;
        res_o.item.rotate_pattern = anc.rotate;
        res_o.item.flip_x         = anc.flip_x;
        res_o.item.flip_y         = anc.flip_y;
        res_o.item.x_scale_log    = anc.x_scale;
        res_o.item.y_scale_log    = anc.y_scale;
        res_o.item.relative_kind  = KIND_UNIFIED;
      end else begin
        xoff = signed'({{4{xd0[7]}}, xd0});
        yoff = signed'({{4{yd0[7]}}, yd0});
        res_o.item.rotate_pattern = rot;
        res_o.item.flip_x         = mx;
        res_o.item.flip_y         = my;
        res_o.item.x_scale_log    = xs;
        res_o.item.y_scale_log    = ys;
        res_o.item.relative_kind  = KIND_COMPOSITE;
      end
      res_o.item.x_position = ax12 + xoff;
      res_o.item.y_position = ay12 + yoff;
    end

    res_o.item.pattern_index    = four ? n_res : {n_res[6:1], 1'b0};
    res_o.item.four_bit_pattern = four;
  end

endmodule

// File: design/relative_sprite_resolver.sv
// relative sprite resolver top level: input register, resolve logic, output register
// depends on rsr_pkg, rsr_resolve and assert_macros.svh
// path: an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle; stalls only while a visible sprite waits on a held result
// reset: synchronous active-low rst_n clears the valid flags of both item stages and the anchor register
`include "assert_macros.svh"
module relative_sprite_resolver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rsr_pkg::out_item_t out_item
);
  import rsr_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  anchor_t   anchor_r;
  anchor_t   anchor_nxt;
  resolve_t  res;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      s1_adv;

  rsr_resolve u_resolve (
    .item_i    (s1_item_r),
    .anchor_i  (anchor_r),
    .res_o     (res),
    .anchor_nxt(anchor_nxt)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!res.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
    end else if (s1_adv) begin
      anchor_r <= anchor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // accepted item lands in the input register
  `RSR_ASSERT_NEXT(a_in_to_s1, clk, rst_n, in_valid && in_ready, s1_valid_r)
  // an empty input register always takes an item
  `RSR_ASSERT_SAME(a_s1_empty_ready, clk, rst_n, !s1_valid_r, in_ready)
  // relative sprite at frame start sees an invisible anchor
  `RSR_ASSERT_SAME(a_rel_frame_start, clk, rst_n,
    s1_valid_r && s1_item_r.frame_start && res.relative, !res.emit)
  // a result is never loaded over one still waiting
  `RSR_ASSERT_SAME(a_no_overwrite, clk, rst_n, s1_adv && res.emit, out_free)

endmodule

// File: verif/relative_sprite_resolver_tb.sv
// testbench for relative_sprite_resolver: directed and random sprite streams, scored
// against an in-bench predictor of the anchor register and offset resolution
// depends on rsr_pkg and the relative_sprite_resolver design
`timescale 1ns / 100ps
module relative_sprite_resolver_tb;
  import rsr_pkg::*;

  localparam int SPRITE_TARGET  = 500;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PAUSE_EVERY    = 150;

  class sprite_scoreboard;
    anchor_t   anchor;
    out_item_t expected_q[$];
    int        failures;

    function new();
      anchor   = '0;
      failures = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    function void check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] got_v);
      if (got_v !== exp_v) begin
        flag($sformatf("%s expected %0d actual %0d", name, exp_v, got_v));
      end
    endfunction

    // decode all five bytes, update the anchor, queue the draw parameters
    function void note_sprite(in_item_t it);
      logic [3:0]        pal;
      logic              mx, my, rot, bit0, vis, ext, is_rel;
      logic              four_px, n6, uni, y8, pat_rel;
      logic [1:0]        xs, ys;
      logic [6:0]        pat;
      logic signed [7:0] dx, dy, swap;
      int                xpos, ypos;
      out_item_t         res;
      {pal, mx, my, rot, bit0} = it.attr2_byte;
      vis     = it.attr3_byte[7];
      ext     = it.attr3_byte[6];
      is_rel  = ext && ((it.attr4_byte & REL_MASK) == REL_CODE);
      four_px = 1'b0;
      n6      = 1'b0;
      uni     = 1'b0;
      y8      = 1'b0;
      pat_rel = 1'b0;
      xs      = 2'd0;
      ys      = 2'd0;
      res     = '0;
      if (it.frame_start) begin
        anchor = '0;
      end
      if (ext) begin
        xs = it.attr4_byte[4:3];
        ys = it.attr4_byte[2:1];
        if (is_rel) begin
          n6      = it.attr4_byte[5];
          pat_rel = it.attr4_byte[0];
        end else begin
          four_px = it.attr4_byte[7];
          n6      = it.attr4_byte[6];
          uni     = it.attr4_byte[5];
          y8      = it.attr4_byte[0];
        end
      end
      pat = {it.attr3_byte[5:0], n6};
      if (!is_rel) begin
        anchor = '{visible: vis, x: {bit0, it.attr0_byte}, y: {y8, it.attr1_byte},
                   pattern: pat, four_bit: four_px, palette: pal, unified: uni,
                   rotate: rot, flip_x: mx, flip_y: my, x_scale: xs, y_scale: ys};
        if (!vis) begin
          return;
        end
        xpos = anchor.x;
        ypos = anchor.y;
        res.palette_offset = pal;
        res.rotate_pattern = rot;
        res.flip_x         = mx;
        res.flip_y         = my;
        res.x_scale_log    = xs;
        res.y_scale_log    = ys;
        res.relative_kind  = KIND_ANCHOR;
      end else begin
        if (!anchor.visible || !vis) begin
          return;
        end
        if (pat_rel) begin
          pat = pat + anchor.pattern;
        end
        res.palette_offset = bit0 ? pal + anchor.palette : pal;
        four_px = anchor.four_bit;
        dx   = it.attr0_byte;
        dy   = it.attr1_byte;
        xpos = anchor.x;
        ypos = anchor.y;
        if (anchor.unified) begin
          // offset follows the anchor's quarter turn and mirrors, 8-bit wrap
          if (anchor.rotate) begin
            swap = dx;
            dx   = -dy;
            dy   = swap;
          end
          if (anchor.flip_x) begin
            dx = -dx;
          end
          if (anchor.flip_y) begin
            dy = -dy;
          end
          xpos += int'(dx) * (1 << anchor.x_scale);
          ypos += int'(dy) * (1 << anchor.y_scale);
          res.rotate_pattern = anchor.rotate;
          res.flip_x         = anchor.flip_x;
          res.flip_y         = anchor.flip_y;
          res.x_scale_log    = anchor.x_scale;
          res.y_scale_log    = anchor.y_scale;
          res.relative_kind  = KIND_UNIFIED;
        end else begin
          xpos += int'(dx);
          ypos += int'(dy);
          res.rotate_pattern = rot;
          res.flip_x         = mx;
          res.flip_y         = my;
          res.x_scale_log    = xs;
          res.y_scale_log    = ys;
          res.relative_kind  = KIND_COMPOSITE;
        end
      end
      if (!four_px) begin
        pat[0] = 1'b0;
      end
      res.x_position       = xpos[11:0];
      res.y_position       = ypos[11:0];
      res.pattern_index    = pat;
      res.four_bit_pattern = four_px;
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected item %p", got));
        return;
      end
      exp_item = expected_q.pop_front();
      check_field("x_position", exp_item.x_position, got.x_position);
      check_field("y_position", exp_item.y_position, got.y_position);
      check_field("pattern_index", exp_item.pattern_index, got.pattern_index);
      check_field("four_bit_pattern", exp_item.four_bit_pattern, got.four_bit_pattern);
      check_field("palette_offset", exp_item.palette_offset, got.palette_offset);
      check_field("rotate_pattern", exp_item.rotate_pattern, got.rotate_pattern);
      check_field("flip_x", exp_item.flip_x, got.flip_x);
      check_field("flip_y", exp_item.flip_y, got.flip_y);
      check_field("x_scale_log", exp_item.x_scale_log, got.x_scale_log);
      check_field("y_scale_log", exp_item.y_scale_log, got.y_scale_log);
      check_field("relative_kind", exp_item.relative_kind, got.relative_kind);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      steady    = 1'b0;
  int        sprites_sent = 0;
  int        idle_cycles  = 0;

  sprite_scoreboard sb = new();

  relative_sprite_resolver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_item);
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[relative_sprite_resolver] ERROR");
    $finish;
  end

  function automatic in_item_t make_anchor(bit fs, bit vis, logic [8:0] xp, logic [8:0] yp,
                                           logic [6:0] pat, bit four, logic [3:0] pal,
                                           bit uni, bit rot, bit mx, bit my,
                                           logic [1:0] xs, logic [1:0] ys);
    in_item_t it;
    it.frame_start = fs;
    it.attr0_byte  = xp[7:0];
    it.attr1_byte  = yp[7:0];
    it.attr2_byte  = {pal, mx, my, rot, xp[8]};
    it.attr3_byte  = {vis, 1'b1, pat[6:1]};
    // an 8-bit anchor cannot carry pattern bit 0 without looking relative
    it.attr4_byte  = {four, pat[0] & four, uni, xs, ys, yp[8]};
    return it;
  endfunction

  function automatic in_item_t make_relative(bit fs, bit vis, logic [7:0] dx, logic [7:0] dy,
                                             logic [6:0] pat, bit pat_rel, logic [3:0] pal,
                                             bit pal_rel, bit rot, bit mx, bit my,
                                             logic [1:0] xs, logic [1:0] ys);
    in_item_t it;
    it.frame_start = fs;
    it.attr0_byte  = dx;
    it.attr1_byte  = dy;
    it.attr2_byte  = {pal, mx, my, rot, pal_rel};
    it.attr3_byte  = {vis, 1'b1, pat[6:1]};
    it.attr4_byte  = {2'b01, pat[0], xs, ys, pat_rel};
    return it;
  endfunction

  task automatic send_sprite(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_sprite(it);
    sprites_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    in_item_t directed_q[$];
    in_item_t it;
    int       next_pause;
    int       rel_count;
    bit       fs;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // relative sprite before any anchor
    directed_q.push_back(make_relative(1, 1, 8'h10, 8'h10, 7'h11, 0, 4'h1, 0, 0, 0, 0, 0, 0));
    // anchor at the field maxima
    directed_q.push_back(make_anchor(0, 1, 9'h1FF, 9'h1FF, 7'h7F, 1, 4'hF, 0, 1, 1, 1, 3, 3));
    // composite: offset extremes, pattern and palette wrap
    directed_q.push_back(make_relative(0, 1, 8'h7F, 8'h80, 7'h7F, 1, 4'hF, 1, 1, 0, 1, 2, 1));
    directed_q.push_back(make_relative(0, 0, 8'h01, 8'h01, 7'h02, 0, 4'h2, 0, 0, 0, 0, 0, 0));
    // 8-bit anchor at the origin, negative composite result
    directed_q.push_back(make_anchor(0, 1, 9'h000, 9'h000, 7'h55, 0, 4'h3, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_relative(0, 1, 8'h80, 8'hFF, 7'h01, 0, 4'h2, 0, 0, 1, 0, 1, 3));
    // invisible anchor still replaces the anchor
    directed_q.push_back(make_anchor(0, 0, 9'h0AA, 9'h055, 7'h0F, 1, 4'h7, 0, 0, 0, 0, 1, 1));
    directed_q.push_back(make_relative(0, 1, 8'h04, 8'h04, 7'h04, 1, 4'h4, 1, 0, 0, 0, 0, 0));
    // unified anchors with every transform, offsets hitting -128
    directed_q.push_back(make_anchor(0, 1, 9'h100, 9'h0FF, 7'h20, 1, 4'h8, 1, 1, 1, 1, 3, 3));
    directed_q.push_back(make_relative(0, 1, 8'h80, 8'h80, 7'h03, 1, 4'h9, 1, 1, 1, 1, 0, 0));
    directed_q.push_back(make_relative(0, 1, 8'h7F, 8'h01, 7'h40, 0, 4'hC, 0, 0, 0, 0, 3, 3));
    directed_q.push_back(make_anchor(0, 1, 9'h080, 9'h080, 7'h10, 1, 4'h1, 1, 1, 0, 0, 1, 2));
    directed_q.push_back(make_relative(0, 1, 8'h05, 8'hFB, 7'h06, 1, 4'hF, 1, 0, 1, 1, 2, 2));
    directed_q.push_back(make_anchor(0, 1, 9'h010, 9'h1F0, 7'h31, 0, 4'h5, 1, 0, 1, 0, 0, 0));
    directed_q.push_back(make_relative(0, 1, 8'h80, 8'h22, 7'h08, 1, 4'h0, 0, 1, 0, 0, 1, 1));
    directed_q.push_back(make_anchor(0, 1, 9'h1E0, 9'h008, 7'h12, 1, 4'hA, 1, 0, 0, 1, 2, 1));
    directed_q.push_back(make_relative(0, 1, 8'h80, 8'h7F, 7'h7E, 1, 4'h7, 1, 0, 0, 0, 3, 0));
    // relative flagged as frame start sees a reset anchor
    directed_q.push_back(make_relative(1, 1, 8'h08, 8'h08, 7'h09, 0, 4'h3, 0, 0, 0, 0, 0, 0));
    // plain anchor whose ignored byte 4 looks relative
    it = make_anchor(1, 1, 9'h0C3, 9'h03C, 7'h2A, 0, 4'h6, 0, 0, 1, 0, 0, 0);
    it.attr3_byte[6] = 1'b0;
    it.attr4_byte    = REL_CODE | 8'h3F;
    directed_q.push_back(it);
    directed_q.push_back(make_relative(0, 1, 8'hF0, 8'h10, 7'h2B, 1, 4'hE, 1, 1, 1, 0, 1, 0));
    directed_q.push_back(make_anchor(1, 1, 9'h000, 9'h000, 7'h00, 0, 4'h0, 0, 0, 0, 0, 0, 0));
    foreach (directed_q[i]) begin
      send_sprite(directed_q[i]);
    end

    next_pause = PAUSE_EVERY;
    while (sprites_sent < SPRITE_TARGET) begin
      steady = (sprites_sent >= 200 && sprites_sent < 300);
      if (sprites_sent >= next_pause) begin
        drain_results();
        next_pause += PAUSE_EVERY;
      end
      if ($urandom_range(0, 99) < 15) begin
        it.frame_start = ($urandom_range(0, 7) == 0);
        it.attr0_byte  = 8'($urandom);
        it.attr1_byte  = 8'($urandom);
        it.attr2_byte  = 8'($urandom);
        it.attr3_byte  = 8'($urandom);
        it.attr4_byte  = 8'($urandom);
        send_sprite(it);
      end else begin
        fs = ($urandom_range(0, 3) == 0);
        send_sprite(make_anchor(fs, $urandom_range(0, 9) != 0, 9'($urandom), 9'($urandom),
                                7'($urandom), 1'($urandom), 4'($urandom), 1'($urandom),
                                1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
                                2'($urandom)));
        rel_count = $urandom_range(0, 6);
        repeat (rel_count) begin
          send_sprite(make_relative(0, $urandom_range(0, 9) != 0, 8'($urandom),
                                    8'($urandom), 7'($urandom), 1'($urandom),
                                    4'($urandom), 1'($urandom), 1'($urandom),
                                    1'($urandom), 1'($urandom), 2'($urandom),
                                    2'($urandom)));
        end
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[relative_sprite_resolver] OK");
    end else begin
      $display("[relative_sprite_resolver] ERROR");
    end
    $finish;
  end

endmodule
